// File: design/sal_pkg.sv
`default_nettype none

package sal_pkg;

  // fixed field widths
  localparam int unsigned CAP_W = 5;
  localparam int unsigned POS_W = 5;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned STATUS_W = 2;

  // capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_LOCATE = 2'd3
  } sal_kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_INDEX = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } sal_status_t;

  // command broadcast to every cell
  typedef struct packed {
    sal_kind_t kind;
    logic      wr_en;
  } sal_cmd_t;

  // flags handed along the row of cells
  typedef struct packed {
    logic hit;
    logic chain;
  } sal_tap_t;

endpackage

`default_nettype wire

// File: design/sorted_array_list.sv
`default_nettype none

// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_ready  | kind, value, position
// out_     | output    | out_valid / out_ready| status, read_value, found_index,
//          |           |                      | entry_count
// cfg_     | input     | cfg_wr_en            | wr_data (capacity in use)
//
// one transfer per cycle on the input: every cell compares and shifts at once,
// and the result is registered, so it is valid in the cycle after the input transfer.
// the critical path is the hit chain rippling through the DEPTH cells.
// a transfer is taken while a result waits, as long as that result leaves the
// same cycle; otherwise the input stalls.
// synchronous reset empties the list and sets capacity to 16.

module sorted_array_list #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sal_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [DATA_WIDTH-1:0]         in_value,
  input  wire logic [sal_pkg::POS_W-1:0]     in_position,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sal_pkg::STATUS_W-1:0]       out_status,
  output logic [DATA_WIDTH-1:0]              out_read_value,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] out_found_index,
  output logic [$clog2(DEPTH+1)-1:0]         out_entry_count,
  input  wire logic                          cfg_wr_en,
  input  wire logic [sal_pkg::CAP_W-1:0]     cfg_wr_data
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > sal_pkg::CAP_W) ? CNT_W : sal_pkg::CAP_W;

  logic [sal_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  logic [sal_pkg::STATUS_W-1:0] status_r;
  logic [sal_pkg::STATUS_W-1:0] status_nxt;
  logic [DATA_WIDTH-1:0]     rd_r;
  logic [DATA_WIDTH-1:0]     rd_nxt;
  logic [IDX_W-1:0]          fidx_r;
  logic [IDX_W-1:0]          fidx_nxt;

  sal_pkg::sal_kind_t kind;
  sal_pkg::sal_cmd_t  cmd;
  logic               in_xfer;
  logic               full;
  logic               bad_index;
  logic               any_hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [DATA_WIDTH-1:0] rd_any;

  logic [DATA_WIDTH-1:0] ent     [DEPTH];
  logic [DATA_WIDTH-1:0] rd_cell [DEPTH];
  sal_pkg::sal_tap_t     tap     [DEPTH];
  logic [DEPTH-1:0]      occ;

  assign kind     = sal_pkg::sal_kind_t'(in_kind);
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // list state checks
  assign full = (count_r != '0) &&
                ((CMP_W'(count_r) >= CMP_W'(cap_r)) || (count_r == CNT_W'(DEPTH)));
  assign bad_index = CMP_W'(in_position) >= CMP_W'(count_r);

  // row of cells
  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_e;
      logic [DATA_WIDTH-1:0] next_e;
      logic                  prev_c;

      assign occ[g] = (count_r > CNT_W'(g));

      if (g == 0) begin : g_first
        assign prev_e = '0;
        assign prev_c = 1'b0;
      end else begin : g_mid
        assign prev_e = ent[g-1];
        assign prev_c = tap[g-1].chain;
      end

      if (g == DEPTH - 1) begin : g_last
        assign next_e = ent[g];
      end else begin : g_inner
        assign next_e = ent[g+1];
      end

      sal_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .IDX        (g)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .value      (in_value),
        .position   (in_position),
        .occupied   (occ[g]),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .prev_chain (prev_c),
        .entry      (ent[g]),
        .tap        (tap[g]),
        .rd_data    (rd_cell[g])
      );
    end
  endgenerate

  // index of the hit cell and the addressed entry
  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    rd_any  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_hit = any_hit | tap[i].hit;
      hit_idx = hit_idx | (tap[i].hit ? IDX_W'(i) : '0);
      rd_any  = rd_any | rd_cell[i];
    end
  end

  // result and state update for the current operation
  always_comb begin
    status_nxt = sal_pkg::STATUS_OK;
    rd_nxt     = '0;
    fidx_nxt   = '0;
    count_nxt  = count_r;
    cmd.kind   = kind;
    cmd.wr_en  = 1'b0;
    case (kind)
      sal_pkg::KIND_INSERT: begin
        if (full) begin
          status_nxt = sal_pkg::STATUS_FULL;
        end else begin
          cmd.wr_en = in_xfer;
          fidx_nxt  = hit_idx;
          count_nxt = count_r + 1'b1;
        end
      end
      sal_pkg::KIND_DELETE: begin
        if (bad_index) begin
          status_nxt = sal_pkg::STATUS_BAD_INDEX;
        end else begin
          cmd.wr_en = in_xfer;
          count_nxt = count_r - 1'b1;
        end
      end
      sal_pkg::KIND_READ: begin
        if (bad_index) begin
          status_nxt = sal_pkg::STATUS_BAD_INDEX;
        end else begin
          rd_nxt = rd_any;
        end
      end
      sal_pkg::KIND_LOCATE: begin
        if (any_hit) begin
          fidx_nxt = hit_idx;
        end else begin
          status_nxt = sal_pkg::STATUS_NOT_FOUND;
        end
      end
      default: status_nxt = sal_pkg::STATUS_OK;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= sal_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (in_xfer) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r <= status_nxt;
      rd_r     <= rd_nxt;
      fidx_r   <= fidx_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_read_value  = rd_r;
  assign out_found_index = fidx_r;
  assign out_entry_count = count_r;

endmodule

`default_nettype wire

// File: design/sal_cell.sv
`default_nettype none

module sal_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX = 0
) (
  input  wire logic                    clk,
  input  wire sal_pkg::sal_cmd_t       cmd,
  input  wire logic [DATA_WIDTH-1:0]   value,
  input  wire logic [sal_pkg::POS_W-1:0] position,
  input  wire logic                    occupied,
  input  wire logic [DATA_WIDTH-1:0]   prev_entry,
  input  wire logic [DATA_WIDTH-1:0]   next_entry,
  input  wire logic                    prev_chain,
  output logic [DATA_WIDTH-1:0]        entry,
  output sal_pkg::sal_tap_t            tap,
  output logic [DATA_WIDTH-1:0]        rd_data
);

  localparam logic [31:0] IDX_L = 32'(IDX);

  logic [DATA_WIDTH-1:0] entry_r;
  logic [DATA_WIDTH-1:0] entry_nxt;
  logic                  greater;
  logic                  equal;
  logic                  pos_match;
  logic                  hit;
  logic                  chain_out;

  // local compares against the broadcast operands
  assign greater   = occupied && ($signed(entry_r) > $signed(value));
  assign equal     = occupied && (entry_r == value);
  assign pos_match = (32'(position) == IDX_L);

  // first cell of the row that the operation selects
  always_comb begin
    case (cmd.kind)
      sal_pkg::KIND_INSERT: hit = (!occupied || greater) && !prev_chain;
      sal_pkg::KIND_LOCATE: hit = equal && !prev_chain;
      sal_pkg::KIND_DELETE: hit = pos_match;
      sal_pkg::KIND_READ:   hit = pos_match;
      default:              hit = 1'b0;
    endcase
  end

  assign chain_out = prev_chain || hit;

  // insert moves entries up from the hit cell, delete moves them down
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.wr_en) begin
      case (cmd.kind)
        sal_pkg::KIND_INSERT: begin
          if (prev_chain) begin
            entry_nxt = prev_entry;
          end else if (hit) begin
            entry_nxt = value;
          end
        end
        sal_pkg::KIND_DELETE: begin
          if (chain_out) begin
            entry_nxt = next_entry;
          end
        end
        default: entry_nxt = entry_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry     = entry_r;
  assign tap.hit   = hit;
  assign tap.chain = chain_out;
  assign rd_data   = pos_match ? entry_r : '0;

endmodule

`default_nettype wire

// File: design/sal_checker.sv
`default_nettype none

module sal_checker #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [sal_pkg::STATUS_W-1:0]  out_status,
  input wire logic [DATA_WIDTH-1:0]         out_read_value,
  input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] out_found_index,
  input wire logic [$clog2(DEPTH+1)-1:0]    out_entry_count
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // a pending result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_read_value) && $stable(out_found_index) && $stable(out_entry_count))
    else $error("result changed while stalled");

  // the input is open whenever no result is pending
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // count never goes past the store depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // failed operations carry zero payload
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != sal_pkg::STATUS_OK) |->
      (out_read_value == '0) && (out_found_index == '0))
    else $error("non-zero payload on failed operation");

  // a dropped insert only happens on a non-empty list
  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sal_pkg::STATUS_FULL) |-> out_entry_count != '0)
    else $error("full status with empty list");

endmodule

bind sorted_array_list sal_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_sal_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_read_value  (out_read_value),
  .out_found_index (out_found_index),
  .out_entry_count (out_entry_count)
);

`default_nettype wire
